// ===== hdl/pcct_pkg.sv =====
package pcct_pkg;

  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;
  localparam int SlotW = 11;
  localparam int OpenW = 16;
  localparam int EntW = 1 + 64 + 64 + OpenW + SlotW;
  localparam logic signed [OpenW-1:0] CountMax = 16'sd32767;

  typedef enum logic [1:0] {
    OP_OPEN        = 2'd0,
    OP_OPEN_DIRECT = 2'd1,
    OP_CLOSE       = 2'd2,
    OP_EVICT       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_FOUND     = 3'd1,
    ST_NO_OPEN       = 3'd2,
    ST_FULL          = 3'd3,
    ST_OWNER_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [63:0]       key;
    logic [63:0]       tag;
    logic [OpenW-1:0]  cnt;
    logic [SlotW-1:0]  slot;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_OWN_RD,
    S_OWN_WAIT,
    S_USCAN,
    S_UFIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [IdxW-1:0]   hit_idx;
    logic              free;
    logic [IdxW-1:0]   free_idx;
  } scan_t;

endpackage

// ===== hdl/pcct_ram.sv =====
module pcct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pcct_scan.sv =====
// Walks the table one entry per cycle while en is high; returns first key match and lowest free entry.
module pcct_scan (
  input  logic                       clk,
  input  logic                       clr,
  input  logic                       en,
  input  logic [pcct_pkg::IdxW-1:0]  idx,
  input  logic [63:0]                key,
  input  pcct_pkg::entry_t           rd,
  output pcct_pkg::scan_t            res
);

  always_ff @(posedge clk) begin
    if (clr) begin
      res <= '0;
    end else if (en) begin
      if (rd.valid && rd.key == key && !res.hit) begin
        res.hit     <= 1'b1;
        res.hit_idx <= idx;
      end
      if (!rd.valid && !res.free) begin
        res.free     <= 1'b1;
        res.free_idx <= idx;
      end
    end
  end

endmodule

// ===== hdl/page_cache_coherence_tracker.sv =====
// Sequence: a sweep of all TableEntries entries, a decide step (with an extra wait for the
// hit entry read on a hit) and a done state. A close that frees a slot then sweeps again
// for the moved owner before its done state.
// Open direct, or any item while tracker_active is 0, goes straight to the done state.
// Throughput: one item at a time; busy drops in the done cycle, where the next start is taken.
// Reset: a clearing pass over every entry with busy high; tracker_active resets to 1.
module page_cache_coherence_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic [1:0]  opcode,
  input  logic [63:0] inode_key,
  input  logic [63:0] content_tag,
  output logic        done,
  output logic        cache_keep,
  output logic        bypass_io,
  output logic [2:0]  status
);

  localparam int IW = pcct_pkg::IdxW;
  localparam int CW = pcct_pkg::CntW;
  localparam int SW = pcct_pkg::SlotW;
  localparam int OW = pcct_pkg::OpenW;

  pcct_pkg::state_t state, state_next;
  logic tracker_active;
  logic [1:0] op;
  logic [63:0] key, tag, moved;
  logic [CW-1:0] ptr;
  logic [CW-1:0] slot_count;
  logic [SW-1:0] fidx;
  logic [IW-1:0] eidx;
  logic rd_vld;
  logic [IW-1:0] rd_idx;
  pcct_pkg::scan_t sres;
  logic scan_clr;

  logic e_we, o_we;
  logic [IW-1:0] e_wa, e_ra, o_wa, o_ra;
  pcct_pkg::entry_t e_wd, e_rd, ent;
  logic [63:0] o_wd, o_rd;

  logic rkeep, rdio;
  pcct_pkg::status_t rst_st;

  pcct_ram #(.Width(pcct_pkg::EntW), .Depth(pcct_pkg::TableEntries)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  pcct_ram #(.Width(64), .Depth(pcct_pkg::TableEntries)) u_own (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
  );

  logic [63:0] scan_key;
  assign scan_key = (state == pcct_pkg::S_USCAN) ? moved : key;

  pcct_scan u_scan (
    .clk(clk), .clr(scan_clr), .en(rd_vld), .idx(rd_idx),
    .key(scan_key), .rd(e_rd), .res(sres)
  );

  wire last_rd = ptr == CW'(pcct_pkg::TableEntries);
  assign busy = state != pcct_pkg::S_IDLE;
  assign e_ra = (state == pcct_pkg::S_DECIDE || state == pcct_pkg::S_UFIX) ?
                sres.hit_idx : ptr[IW-1:0];
  assign ent = e_rd;

  // decision logic
  logic signed [OW-1:0] n;
  logic sl_full;
  logic [OW-1:0] absn, n1;
  logic d_ewe, d_add, d_close0, d_done;
  pcct_pkg::entry_t d_ent;
  logic d_keep, d_dio;
  pcct_pkg::status_t d_st;
  logic [IW-1:0] d_ea;

  assign n = signed'(ent.cnt);
  assign sl_full = slot_count >= CW'(pcct_pkg::TableEntries);
  assign absn = n[OW-1] ? OW'(-n) : ent.cnt;
  assign n1 = absn - OW'(1);

  always_comb begin
    d_ewe = 1'b0; d_add = 1'b0; d_close0 = 1'b0; d_done = 1'b1;
    d_ent = ent; d_keep = 1'b0; d_dio = 1'b0; d_st = pcct_pkg::ST_OK;
    d_ea = sres.hit_idx;
    case (op)
      pcct_pkg::OP_OPEN: begin
        if (!sres.hit) begin
          if (!sres.free || sl_full) begin
            d_st = pcct_pkg::ST_FULL;
          end else begin
            d_ea = sres.free_idx; d_ewe = 1'b1; d_add = 1'b1; d_keep = 1'b1;
            d_ent = '{valid: 1'b1, key: key, tag: tag, cnt: OW'(1),
                      slot: slot_count[SW-1:0]};
          end
        end else if (ent.tag == tag) begin
          if (n < 0) begin
            if (n <= -pcct_pkg::CountMax) begin
              d_st = pcct_pkg::ST_FULL;
            end else begin
              d_ewe = 1'b1; d_ent.cnt = ent.cnt - OW'(1);
            end
          end else if (n >= pcct_pkg::CountMax || (n == 0 && sl_full)) begin
            d_st = pcct_pkg::ST_FULL;
          end else begin
            d_ewe = 1'b1; d_ent.cnt = ent.cnt + OW'(1); d_keep = 1'b1;
            if (n == 0) begin
              d_add = 1'b1; d_ent.slot = slot_count[SW-1:0];
            end
          end
        end else if (n != 0) begin
          d_keep = 1'b1; d_dio = 1'b1;
        end else if (sl_full) begin
          d_st = pcct_pkg::ST_FULL;
        end else begin
          d_ewe = 1'b1; d_add = 1'b1; d_ent.tag = tag;
          d_ent.slot = slot_count[SW-1:0]; d_ent.cnt = '1;
        end
      end
      pcct_pkg::OP_CLOSE: begin
        if (!sres.hit) begin
          d_st = pcct_pkg::ST_NOT_FOUND;
        end else if (n == 0) begin
          d_st = pcct_pkg::ST_NO_OPEN;
        end else begin
          d_ewe = 1'b1; d_ent.cnt = n1;
          if (n1 == '0) begin
            d_ent.slot = '0;
            if (CW'(ent.slot) >= slot_count) begin
              d_st = pcct_pkg::ST_OWNER_MISSING;
            end else begin
              d_close0 = 1'b1; d_done = 1'b0;
            end
          end
        end
      end
      pcct_pkg::OP_EVICT: begin
        if (!sres.hit) begin
          d_st = pcct_pkg::ST_NOT_FOUND;
        end else begin
          d_ewe = 1'b1; d_ent.valid = 1'b0;
        end
      end
      default: begin
        d_keep = 1'b1; d_dio = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcct_pkg::S_CLEAR:    if (last_rd) state_next = pcct_pkg::S_IDLE;
      pcct_pkg::S_IDLE: begin
        if (start) begin
          if (opcode == pcct_pkg::OP_OPEN_DIRECT || !tracker_active) begin
            state_next = pcct_pkg::S_DONE;
          end else begin
            state_next = pcct_pkg::S_SCAN;
          end
        end
      end
      pcct_pkg::S_SCAN:     if (!rd_vld && last_rd) state_next = pcct_pkg::S_DECIDE;
      pcct_pkg::S_DECIDE: begin
        if (sres.hit && ptr == '0) begin
          state_next = state;
        end else if (!sres.hit || ptr != '0) begin
          state_next = d_done ? pcct_pkg::S_DONE : pcct_pkg::S_OWN_RD;
        end
      end
      pcct_pkg::S_OWN_RD:   state_next = pcct_pkg::S_OWN_WAIT;
      pcct_pkg::S_OWN_WAIT: state_next = pcct_pkg::S_USCAN;
      pcct_pkg::S_USCAN:    if (!rd_vld && last_rd) state_next = pcct_pkg::S_UFIX;
      pcct_pkg::S_UFIX: begin
        if (!sres.hit || ptr != '0) state_next = pcct_pkg::S_DONE;
      end
      pcct_pkg::S_DONE:     state_next = pcct_pkg::S_IDLE;
      default:              state_next = pcct_pkg::S_IDLE;
    endcase
  end

  // ptr: sweep address; in DECIDE/UFIX ptr==0 with a hit means the hit entry read is pending
  always_comb begin
    e_we = 1'b0; e_wa = ptr[IW-1:0]; e_wd = '0;
    o_we = 1'b0; o_wa = fidx[IW-1:0]; o_wd = key; o_ra = IW'(slot_count - CW'(1));
    scan_clr = 1'b0;
    unique case (state)
      pcct_pkg::S_CLEAR: e_we = !last_rd;
      pcct_pkg::S_IDLE: scan_clr = 1'b1;
      pcct_pkg::S_DECIDE: begin
        if (ptr != '0 || !sres.hit) begin
          e_we = d_ewe; e_wa = d_ea; e_wd = d_ent;
          o_we = d_add; o_wa = slot_count[IW-1:0];
        end
      end
      // slot_count is already decremented here: it indexes the last slot
      pcct_pkg::S_OWN_RD: o_ra = slot_count[IW-1:0];
      pcct_pkg::S_OWN_WAIT: begin
        o_we = 1'b1; o_wa = fidx[IW-1:0]; o_wd = o_rd;
        scan_clr = 1'b1;
      end
      pcct_pkg::S_UFIX: begin
        if (ptr != '0 && sres.hit_idx != eidx) begin
          e_we = 1'b1; e_wa = sres.hit_idx; e_wd = ent; e_wd.slot = fidx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcct_pkg::S_CLEAR;
      ptr <= '0;
      slot_count <= '0;
      tracker_active <= 1'b1;
      rd_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) tracker_active <= cfg_wdata;
      done <= state == pcct_pkg::S_DONE;
      rd_vld <= 1'b0;
      unique case (state)
        pcct_pkg::S_CLEAR: ptr <= last_rd ? '0 : ptr + CW'(1);
        pcct_pkg::S_IDLE: ptr <= '0;
        pcct_pkg::S_SCAN, pcct_pkg::S_USCAN: begin
          if (!last_rd) begin
            rd_vld <= 1'b1;
            ptr <= ptr + CW'(1);
          end else if (!rd_vld) begin
            ptr <= '0;
          end
        end
        pcct_pkg::S_DECIDE, pcct_pkg::S_UFIX: begin
          if (ptr == '0 && sres.hit) ptr <= CW'(1);
          else ptr <= '0;
          if (state == pcct_pkg::S_DECIDE && (ptr != '0 || !sres.hit)) begin
            if (d_add) slot_count <= slot_count + CW'(1);
            if (d_close0) slot_count <= slot_count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx <= ptr[IW-1:0];
    if (state == pcct_pkg::S_IDLE) begin
      op <= opcode; key <= inode_key; tag <= content_tag;
      rkeep <= opcode == pcct_pkg::OP_OPEN_DIRECT;
      rdio <= opcode == pcct_pkg::OP_OPEN_DIRECT;
      rst_st <= pcct_pkg::ST_OK;
    end
    if (state == pcct_pkg::S_DECIDE && (ptr != '0 || !sres.hit)) begin
      rkeep <= d_keep; rdio <= d_dio; rst_st <= d_st;
      fidx <= ent.slot; eidx <= sres.hit_idx;
    end
    if (state == pcct_pkg::S_OWN_WAIT) moved <= o_rd;
    if (state == pcct_pkg::S_UFIX && !sres.hit) rst_st <= pcct_pkg::ST_OWNER_MISSING;
  end

  assign cache_keep = rkeep;
  assign bypass_io = rdio;
  assign status = rst_st;

  // DECIDE/UFIX use ptr==0 with a hit as a wait while the hit entry is read
  // back: e_ra points at the hit entry there, and ent is the read data.

`ifndef ASSERT_OFF
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CW'(pcct_pkg::TableEntries))
    else $error("slot count overflow");
  a_idle_no_we: assert property (@(posedge clk) disable iff (rst)
    state == pcct_pkg::S_IDLE |-> !e_we && !o_we)
    else $error("memory write while idle");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int Depth = pcct_pkg::TableEntries;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic              keep;
    logic              dio;
    pcct_pkg::status_t st;
  } answer_t;

  typedef struct {
    pcct_pkg::op_t op;
    logic [63:0]   key;
    logic [63:0]   tag;
    bit            typed;
    answer_t       ans;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_we;
  logic        cfg_wdata;
  logic [1:0]  opcode;
  logic [63:0] inode_key;
  logic [63:0] content_tag;
  logic        done;
  logic        cache_keep;
  logic        bypass_io;
  logic [2:0]  status;

  page_cache_coherence_tracker u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .opcode(opcode), .inode_key(inode_key), .content_tag(content_tag),
    .done(done), .cache_keep(cache_keep), .bypass_io(bypass_io), .status(status)
  );

  // tracker mirror
  bit          mir_active;
  bit          mir_valid [Depth];
  logic [63:0] mir_key   [Depth];
  logic [63:0] mir_tag   [Depth];
  int          mir_cnt   [Depth];
  int          mir_slot  [Depth];
  logic [63:0] mir_owner [Depth];
  int          mir_slots;

  answer_t     pending_answers[$];
  int          errors;
  int          idle_cycles;
  int          n_items;
  int          n_checked;
  logic [63:0] key_pool[16];
  logic [63:0] tag_pool[4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int lookup(logic [63:0] key);
    for (int i = 0; i < Depth; i++)
      if (mir_valid[i] && mir_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < Depth; i++)
      if (!mir_valid[i]) return i;
    return -1;
  endfunction

  function automatic int take_slot(logic [63:0] owner);
    mir_owner[mir_slots] = owner;
    mir_slots++;
    return mir_slots - 1;
  endfunction

  function automatic answer_t track_item(pcct_pkg::op_t op, logic [63:0] key,
                                         logic [63:0] tag);
    answer_t a;
    int e, f, n, idx, last, u;
    logic [63:0] moved;
    a = '{keep: 1'b0, dio: 1'b0, st: pcct_pkg::ST_OK};
    if (op == pcct_pkg::OP_OPEN_DIRECT) begin
      a.keep = 1'b1;
      a.dio = 1'b1;
      return a;
    end
    if (!mir_active) return a;
    e = lookup(key);
    case (op)
      pcct_pkg::OP_OPEN: begin
        if (e < 0) begin
          f = first_free();
          if (f < 0 || mir_slots >= Depth) begin
            a.st = pcct_pkg::ST_FULL;
            return a;
          end
          mir_valid[f] = 1'b1;
          mir_key[f] = key;
          mir_tag[f] = tag;
          mir_cnt[f] = 1;
          mir_slot[f] = take_slot(key);
          a.keep = 1'b1;
          return a;
        end
        n = mir_cnt[e];
        if (mir_tag[e] == tag) begin
          if (n < 0) begin
            // flush in progress: count another open, no caching
            if (n <= -32767) a.st = pcct_pkg::ST_FULL;
            else mir_cnt[e] = n - 1;
            return a;
          end
          if (n >= 32767 || (n == 0 && mir_slots >= Depth)) begin
            a.st = pcct_pkg::ST_FULL;
            return a;
          end
          if (n == 0) mir_slot[e] = take_slot(key);
          mir_cnt[e] = n + 1;
          a.keep = 1'b1;
          return a;
        end
        if (n != 0) begin
          a.keep = 1'b1;
          a.dio = 1'b1;
          return a;
        end
        if (mir_slots >= Depth) begin
          a.st = pcct_pkg::ST_FULL;
          return a;
        end
        mir_tag[e] = tag;
        mir_slot[e] = take_slot(key);
        mir_cnt[e] = -1;
      end
      pcct_pkg::OP_CLOSE: begin
        if (e < 0) begin
          a.st = pcct_pkg::ST_NOT_FOUND;
          return a;
        end
        n = mir_cnt[e];
        if (n == 0) begin
          a.st = pcct_pkg::ST_NO_OPEN;
          return a;
        end
        if (n < 0) n = -n;
        n--;
        mir_cnt[e] = n;
        if (n != 0) return a;
        idx = mir_slot[e];
        mir_slot[e] = 0;
        if (idx >= mir_slots) begin
          a.st = pcct_pkg::ST_OWNER_MISSING;
          return a;
        end
        // compaction: last slot fills the hole
        last = mir_slots - 1;
        moved = mir_owner[last];
        mir_owner[idx] = moved;
        mir_slots = last;
        u = lookup(moved);
        if (u < 0) a.st = pcct_pkg::ST_OWNER_MISSING;
        else if (u != e) mir_slot[u] = idx;
      end
      default: begin
        if (e < 0) a.st = pcct_pkg::ST_NOT_FOUND;
        else mir_valid[e] = 1'b0;
      end
    endcase
    return a;
  endfunction

  task automatic send_item(pcct_pkg::op_t op, logic [63:0] key, logic [63:0] tag,
                           bit typed, answer_t typed_ans);
    answer_t a;
    int gap, r;
    opcode <= op;
    inode_key <= key;
    content_tag <= tag;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = track_item(op, key, tag);
    pending_answers.push_back(typed ? typed_ans : a);
    n_items++;
    r = $urandom_range(0, 99);
    if (r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_active(bit v);
    @(posedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    mir_active = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_items(int count);
    pcct_pkg::op_t op;
    logic [63:0] key, tag;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = pcct_pkg::OP_OPEN;
      else if (r < 75) op = pcct_pkg::OP_CLOSE;
      else if (r < 80) op = pcct_pkg::OP_OPEN_DIRECT;
      else op = pcct_pkg::OP_EVICT;
      key = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 15)];
      tag = ($urandom_range(0, 9) == 0) ? rand64() : tag_pool[$urandom_range(0, 3)];
      send_item(op, key, tag, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with nothing pending: keep=%0b bypass=%0b status=%0d",
                   $time, cache_keep, bypass_io, status);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          n_checked++;
          if (cache_keep !== want.keep) begin
            $display("%0t: cache_keep expected %0b actual %0b", $time, want.keep, cache_keep);
            errors++;
          end
          if (bypass_io !== want.dio) begin
            $display("%0t: bypass_io expected %0b actual %0b", $time, want.dio, bypass_io);
            errors++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, %0d results pending", $time, pending_answers.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [63:0] kmax, tmax;
    int waited;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    opcode = pcct_pkg::OP_OPEN;
    inode_key = '0;
    content_tag = '0;
    rst = 1'b1;
    errors = 0;
    n_items = 0;
    n_checked = 0;
    mir_active = 1'b1;
    mir_slots = 0;
    for (int i = 0; i < Depth; i++) begin
      mir_valid[i] = 1'b0;
      mir_cnt[i] = 0;
      mir_slot[i] = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = rand64();
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = rand64();
    tag_pool[3] = rand64();
    kmax = '1;
    tmax = '1;

    rows = '{
      '{pcct_pkg::OP_CLOSE,       64'd5, 64'd0, 1'b1, '{1'b0, 1'b0, pcct_pkg::ST_NOT_FOUND}},
      '{pcct_pkg::OP_EVICT,       64'd5, 64'd0, 1'b1, '{1'b0, 1'b0, pcct_pkg::ST_NOT_FOUND}},
      '{pcct_pkg::OP_OPEN_DIRECT, kmax,  tmax,  1'b1, '{1'b1, 1'b1, pcct_pkg::ST_OK}},
      '{pcct_pkg::OP_OPEN,        64'd0, 64'd0, 1'b1, '{1'b1, 1'b0, pcct_pkg::ST_OK}},
      '{pcct_pkg::OP_OPEN,        64'd0, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_OPEN,        64'd0, tmax,  1'b1, '{1'b1, 1'b1, pcct_pkg::ST_OK}},
      '{pcct_pkg::OP_CLOSE,       64'd0, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd0, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd0, 64'd0, 1'b1, '{1'b0, 1'b0, pcct_pkg::ST_NO_OPEN}},
      '{pcct_pkg::OP_OPEN,        64'd0, tmax,  1'b0, '0},
      '{pcct_pkg::OP_OPEN,        64'd0, tmax,  1'b0, '0},
      '{pcct_pkg::OP_OPEN_DIRECT, 64'd0, tmax,  1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd0, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd0, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_OPEN,        kmax,  64'd5, 1'b0, '0},
      '{pcct_pkg::OP_OPEN,        64'd7, 64'd1, 1'b0, '0},
      '{pcct_pkg::OP_EVICT,       kmax,  64'd0, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd7, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_OPEN,        kmax,  64'd9, 1'b0, '0},
      '{pcct_pkg::OP_OPEN,        64'd8, 64'd2, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       kmax,  64'd0, 1'b0, '0},
      '{pcct_pkg::OP_CLOSE,       64'd8, 64'd0, 1'b0, '0},
      '{pcct_pkg::OP_EVICT,       64'd0, 64'd0, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_active(1'b1);
    foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].tag, rows[i].typed, rows[i].ans);

    random_items(350);
    write_active(1'b0);
    random_items(120);
    write_active(1'b1);
    random_items(150);
    // fill the table and slot list past capacity
    for (int i = 0; i < 1040; i++) send_item(pcct_pkg::OP_OPEN, rand64(), rand64(), 1'b0, '0);
    random_items(80);
    write_active(1'b0);
    random_items(20);
    write_active(1'b1);
    random_items(20);

    @(posedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (Depth * 2 + 8) @(posedge clk);

    $display("Ran %0d items (open, direct, close, evict; tracker on and off; table full),",
             n_items);
    $display("%0d results compared, %0d left pending.", n_checked, pending_answers.size());
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
